[hdl/ccs_pkg.sv]
`default_nettype none

package ccs_pkg;

    // Item fields
    localparam int FIELD_W   = 16;
    localparam int Y_W       = 48;
    localparam int INDEX_W   = 10;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 64;

    // Time step register, unsigned Q0.16
    localparam int DT_W = 16;
    localparam logic [DT_W-1:0] DT_RESET = 16'hFFFF;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_DT_SCALE = 1'b0;

    // Default sizes
    localparam int MAX_LEN_DEF     = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    typedef struct packed {
        logic mem_wr;
        logic acc_clear;
        logic rd_issue;
        logic scale_lo;
        logic scale_hi;
        logic out_load;
        logic out_ovf;
    } ccs_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } ccs_sts_t;

endpackage

`default_nettype wire

[hdl/causal_convolution_scaled.sv]
// Causal convolution of two sample streams, scaled by a time step. Each input item carries
// sample n of signals a and b (signed Q1.15) and returns one item with
// y[n] = floor(dt_scale * sum_{k=0..n} a[k]*b[n-k] / 2^16), saturated to signed 48 bits,
// with index n. A start mark in tuser makes the item sample zero of a new pair. Once
// MAX_LEN samples are stored, further items are dropped and answered with overflow set,
// y = 0 and index = 0, until the next start mark. Items are handled one at a time by the
// single multiply-accumulate unit, which reads one pair of stored samples per cycle; a
// dropped item skips the accumulation. A finished result waits in an output register
// while the next item is accepted. dt_scale (unsigned Q0.16, reset 0xFFFF) lies at byte
// address 0. The user must write it only while the block is idle; the block itself
// does not enforce this.
`default_nettype none

module causal_convolution_scaled #(
    parameter int MAX_LEN     = ccs_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = ccs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ccs_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [15:0] sample_a, [31:16] sample_b
    input  logic [0:0]                       s_axis_tuser,  // [0] start_req
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ccs_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [47:0] y, [57:48] index, zeros
    output logic [0:0]                       m_axis_tuser,  // [0] overflow
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ccs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ccs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ccs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import ccs_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);

    ccs_cmd_t                cmd;
    ccs_sts_t                sts;
    logic [IDX_W-1:0]        wr_idx;
    logic [IDX_W-1:0]        rd_idx_a;
    logic [IDX_W-1:0]        rd_idx_b;
    logic [INDEX_W-1:0]      out_index;
    logic signed [Y_W-1:0]   m_y;
    logic [INDEX_W-1:0]      m_index;
    logic                    m_ovf;

    logic [DT_W-1:0]         dt_scale_reg;
    logic [REG_IDX_W-1:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt_scale_reg <= DT_RESET;
        end else if (psel && penable && pwrite && pready && (reg_idx == REG_DT_SCALE)) begin
            dt_scale_reg <= pwdata[DT_W-1:0];
        end
    end

    assign prdata = (reg_idx == REG_DT_SCALE) ? APB_DATA_W'(dt_scale_reg) : '0;

    ccs_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_start   (s_axis_tuser[0]),
        .sts       (sts),
        .cmd       (cmd),
        .s_ready   (s_axis_tready),
        .wr_idx    (wr_idx),
        .rd_idx_a  (rd_idx_a),
        .rd_idx_b  (rd_idx_b),
        .out_index (out_index)
    );

    ccs_datapath #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .sample_a_in (s_axis_tdata[FIELD_W-1:0]),
        .sample_b_in (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .dt_scale    (dt_scale_reg),
        .wr_idx      (wr_idx),
        .rd_idx_a    (rd_idx_a),
        .rd_idx_b    (rd_idx_b),
        .out_index   (out_index),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_y         (m_y),
        .m_index     (m_index),
        .m_ovf       (m_ovf)
    );

    assign m_axis_tdata = {{(M_TDATA_W-Y_W-INDEX_W){1'b0}}, m_index, m_y};
    assign m_axis_tuser = m_ovf;

endmodule

`default_nettype wire

[hdl/ccs_ctrl.sv]
`default_nettype none

module ccs_ctrl #(
    parameter int MAX_LEN = ccs_pkg::MAX_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_start,
    input  ccs_pkg::ccs_sts_t             sts,
    output ccs_pkg::ccs_cmd_t             cmd,
    output logic                          s_ready,
    output logic [$clog2(MAX_LEN)-1:0]    wr_idx,
    output logic [$clog2(MAX_LEN)-1:0]    rd_idx_a,
    output logic [$clog2(MAX_LEN)-1:0]    rd_idx_b,
    output logic [ccs_pkg::INDEX_W-1:0]   out_index
);
    import ccs_pkg::*;

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_SCALE_LO,
        ST_SCALE_HI,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  n_reg;
    logic [IDX_W-1:0]  k_reg;
    logic              ovf_reg;

    logic [CNT_W-1:0]  eff_count;
    logic              at_limit;
    logic              accept;

    // A start mark restarts the run at sample zero
    assign eff_count = s_start ? '0 : count_reg;
    assign at_limit  = (eff_count == CNT_W'(MAX_LEN));
    assign accept    = (state_reg == ST_IDLE) && s_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (at_limit) begin
                            // drop the item, count holds at the limit
                            ovf_reg   <= 1'b1;
                            state_reg <= ST_EMIT;
                        end else begin
                            ovf_reg   <= 1'b0;
                            n_reg     <= eff_count[IDX_W-1:0];
                            k_reg     <= '0;
                            count_reg <= eff_count + 1'b1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE: begin
                    if (k_reg == n_reg) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (!sts.pipe_busy) begin
                        state_reg <= ST_SCALE_LO;
                    end
                end
                ST_SCALE_LO: begin
                    state_reg <= ST_SCALE_HI;
                end
                ST_SCALE_HI: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (sts.out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        cmd           = '0;
        cmd.mem_wr    = accept && !at_limit;
        cmd.acc_clear = accept && !at_limit;
        cmd.rd_issue  = (state_reg == ST_ISSUE);
        cmd.scale_lo  = (state_reg == ST_SCALE_LO);
        cmd.scale_hi  = (state_reg == ST_SCALE_HI);
        cmd.out_load  = (state_reg == ST_EMIT) && sts.out_free;
        cmd.out_ovf   = ovf_reg;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign wr_idx    = eff_count[IDX_W-1:0];
    assign rd_idx_a  = k_reg;
    assign rd_idx_b  = n_reg - k_reg;
    assign out_index = ovf_reg ? '0 : INDEX_W'(n_reg);

endmodule

`default_nettype wire

[hdl/ccs_datapath.sv]
`default_nettype none

module ccs_datapath #(
    parameter int MAX_LEN     = ccs_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = ccs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ccs_pkg::ccs_cmd_t                  cmd,
    output ccs_pkg::ccs_sts_t                  sts,
    input  logic [ccs_pkg::FIELD_W-1:0]        sample_a_in,
    input  logic [ccs_pkg::FIELD_W-1:0]        sample_b_in,
    input  logic [ccs_pkg::DT_W-1:0]           dt_scale,
    input  logic [$clog2(MAX_LEN)-1:0]         wr_idx,
    input  logic [$clog2(MAX_LEN)-1:0]         rd_idx_a,
    input  logic [$clog2(MAX_LEN)-1:0]         rd_idx_b,
    input  logic [ccs_pkg::INDEX_W-1:0]        out_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [ccs_pkg::Y_W-1:0]     m_y,
    output logic [ccs_pkg::INDEX_W-1:0]        m_index,
    output logic                               m_ovf
);
    import ccs_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int PROD_W = 2 * SB;
    localparam int ACC_W  = PROD_W + $clog2(MAX_LEN) + 1;
    localparam int HI_W   = ACC_W - DT_W;
    localparam int MW     = (HI_W > DT_W + 1) ? HI_W : DT_W + 1;
    localparam int SP_W   = MW + DT_W + 1;
    localparam int EW     = (SP_W + 1 > Y_W + 1) ? SP_W + 1 : Y_W + 1;

    localparam logic signed [EW-1:0] Y_MAX_E = {{(EW-Y_W+1){1'b0}}, {(Y_W-1){1'b1}}};
    localparam logic signed [EW-1:0] Y_MIN_E = {{(EW-Y_W+1){1'b1}}, {(Y_W-1){1'b0}}};

    logic signed [SB-1:0]     wa;
    logic signed [SB-1:0]     wb;
    logic signed [SB-1:0]     mem_a [MAX_LEN];
    logic signed [SB-1:0]     mem_b [MAX_LEN];
    logic signed [SB-1:0]     rd_a_reg;
    logic signed [SB-1:0]     rd_b_reg;
    logic                     vld1_reg;
    logic                     vld2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [HI_W-1:0]   hi_part;
    logic signed [MW-1:0]     lo_ext;
    logic signed [MW-1:0]     mul_a;
    logic signed [DT_W:0]     scale_op;
    logic signed [SP_W-1:0]   mul_out;
    logic [DT_W-1:0]          part_reg;
    logic signed [SP_W-1:0]   hi_reg;
    logic signed [EW-1:0]     hi_ext;
    logic [EW-1:0]            part_ext;
    logic signed [EW-1:0]     sum_ext;
    logic signed [Y_W-1:0]    y_sat;

    logic                     out_vld_reg;
    logic signed [Y_W-1:0]    out_y_reg;
    logic [INDEX_W-1:0]       out_idx_reg;
    logic                     out_ovf_reg;

    // Low SAMPLE_BITS bits as two's complement, zero-extended if wider
    if (SAMPLE_BITS <= FIELD_W) begin : g_trunc
        assign wa = sample_a_in[SB-1:0];
        assign wb = sample_b_in[SB-1:0];
    end else begin : g_ext
        assign wa = SB'(sample_a_in);
        assign wb = SB'(sample_b_in);
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem_a[wr_idx] <= wa;
            mem_b[wr_idx] <= wb;
        end
        if (cmd.rd_issue) begin
            rd_a_reg <= mem_a[rd_idx_a];
            rd_b_reg <= mem_b[rd_idx_b];
        end
    end

    // Multiply-accumulate: read, product, sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end else begin
            vld1_reg <= cmd.rd_issue;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (vld1_reg) begin
            prod_reg <= rd_a_reg * rd_b_reg;
        end
        if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (vld2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // floor(acc * dt / 2^16) = (acc >>> 16) * dt + floor(lo16 * dt / 2^16)
    assign hi_part  = acc_reg[ACC_W-1:DT_W];
    assign lo_ext   = MW'({1'b0, acc_reg[DT_W-1:0]});
    assign mul_a    = cmd.scale_hi ? MW'(hi_part) : lo_ext;
    assign scale_op = {1'b0, dt_scale};
    assign mul_out  = mul_a * scale_op;

    always_ff @(posedge aclk) begin
        if (cmd.scale_lo) begin
            part_reg <= mul_out[2*DT_W-1:DT_W];
        end
        if (cmd.scale_hi) begin
            hi_reg <= mul_out;
        end
    end

    assign hi_ext   = EW'(hi_reg);
    assign part_ext = EW'(part_reg);
    assign sum_ext  = hi_ext + $signed(part_ext);

    always_comb begin
        priority if (sum_ext > Y_MAX_E) begin
            y_sat = Y_MAX_E[Y_W-1:0];
        end else if (sum_ext < Y_MIN_E) begin
            y_sat = Y_MIN_E[Y_W-1:0];
        end else begin
            y_sat = sum_ext[Y_W-1:0];
        end
    end

    // Output register parts the result side from the work
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_y_reg   <= cmd.out_ovf ? '0 : y_sat;
            out_idx_reg <= out_index;
            out_ovf_reg <= cmd.out_ovf;
        end
    end

    assign sts.pipe_busy = vld1_reg || vld2_reg;
    assign sts.out_free  = !out_vld_reg || m_ready;

    assign m_valid = out_vld_reg;
    assign m_y     = out_y_reg;
    assign m_index = out_idx_reg;
    assign m_ovf   = out_ovf_reg;

endmodule

`default_nettype wire

[hdl/ccs_checker.sv]
`default_nettype none

module ccs_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [ccs_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic [0:0]                       m_axis_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ccs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ccs_pkg::APB_DATA_W-1:0]   pwdata,
    input  logic [ccs_pkg::APB_DATA_W-1:0]   prdata,
    input  logic                             pready
);
    import ccs_pkg::*;

    // One item at a time: input closes right after an item is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // A dropped item reports zero value and zero index
    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[Y_W+INDEX_W-1:0] == '0))
        else $error("overflow result carries data");

    // Written time step reads back
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && (paddr[APB_ADDR_W-1:2] == REG_DT_SCALE))
        |=> ((paddr[APB_ADDR_W-1:2] != REG_DT_SCALE)
             || (prdata[DT_W-1:0] == $past(pwdata[DT_W-1:0]))))
        else $error("time step readback mismatch");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind causal_convolution_scaled ccs_checker u_ccs_checker (.*);

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccs_pkg::*;

    localparam int RUN_MAX      = MAX_LEN_DEF;
    localparam int QUIET_LIMIT  = 8000;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;
    localparam longint Y_TOP    = (64'sd1 <<< (Y_W - 1)) - 1;
    localparam longint Y_BOTTOM = -Y_TOP - 1;

    typedef struct packed {
        logic [Y_W-1:0]     y;
        logic [INDEX_W-1:0] index;
        logic               overflow;
    } conv_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;   // [15:0] sample_a, [31:16] sample_b
    logic [0:0]            s_axis_tuser;   // [0] start_req
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // [47:0] y, [57:48] index, zeros above
    logic [0:0]            m_axis_tuser;   // [0] overflow
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state
    logic signed [FIELD_W-1:0] hist_a [RUN_MAX];
    logic signed [FIELD_W-1:0] hist_b [RUN_MAX];
    int                        run_len  = 0;
    logic [DT_W-1:0]           dt_model = DT_RESET;

    conv_result_t conv_expect [$];
    int           fails     = 0;
    bit           tx_gaps   = 1'b1;
    bit           rx_stalls = 1'b1;
    int           rx_hold   = 0;

    causal_convolution_scaled uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Scaled causal convolution of the current run, one sample pair at a time
    function automatic conv_result_t conv_predict(input logic [FIELD_W-1:0] a,
                                                  input logic [FIELD_W-1:0] b,
                                                  input logic start);
        conv_result_t r;
        longint       acc;
        longint       scaled;
        int           n;
        if (start)
            run_len = 0;
        if (run_len >= RUN_MAX) begin
            // full: drop the item, hold the count until the next start mark
            run_len    = RUN_MAX;
            r.y        = '0;
            r.index    = '0;
            r.overflow = 1'b1;
            return r;
        end
        n         = run_len;
        hist_a[n] = a;
        hist_b[n] = b;
        run_len   = n + 1;
        acc       = 0;
        for (int k = 0; k <= n; k++)
            acc += longint'(hist_a[k]) * longint'(hist_b[n - k]);
        // floor division by 2^16 via arithmetic shift
        scaled = (acc * longint'(dt_model)) >>> 16;
        if (scaled > Y_TOP)
            scaled = Y_TOP;
        else if (scaled < Y_BOTTOM)
            scaled = Y_BOTTOM;
        r.y        = scaled[Y_W-1:0];
        r.index    = n[INDEX_W-1:0];
        r.overflow = 1'b0;
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
                               input logic start);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 15) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= start;
        do @(posedge aclk); while (!s_axis_tready);
        conv_expect.push_back(conv_predict(a, b, start));
    endtask

    // Drop valid and let every pending result come back
    task automatic wait_idle();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (conv_expect.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_DT_SCALE)
            dt_model = data[DT_W-1:0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_dt_scale();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_DT_SCALE, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[DT_W-1:0] !== dt_model) begin
            $error("dt_scale: expected %0d, got %0d", dt_model, prdata[DT_W-1:0]);
            fails++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_register_access();
        check_dt_scale();
        // writes to an unmapped index must leave dt_scale alone
        reg_write(REG_SPARE, 32'h0000_1234);
        check_dt_scale();
    endtask

    task automatic test_first_without_start();
        send_sample(16'h7FFF, 16'h7FFF, 1'b0);
        send_sample(16'h8000, 16'h8000, 1'b0);
        send_sample(16'h8000, 16'h7FFF, 1'b0);
        send_sample(16'hFFFF, 16'h0001, 1'b0);
        wait_idle();
    endtask

    task automatic test_start_mark();
        send_sample(16'h8000, 16'h8000, 1'b1);
        send_sample(16'h8000, 16'h8000, 1'b1);
        send_sample(rand_sample(), rand_sample(), 1'b1);
        send_sample(16'h7FFF, 16'h8000, 1'b0);
        wait_idle();
    endtask

    task automatic test_scale_extremes();
        logic [DT_W-1:0] scales [4];
        scales = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};
        foreach (scales[i]) begin
            reg_write(REG_DT_SCALE, {16'h0000, scales[i]});
            check_dt_scale();
            send_sample(16'h8000, 16'h8000, 1'b1);
            send_sample(16'h7FFF, 16'h8000, 1'b0);
            send_sample(16'hFFFF, 16'h7FFF, 1'b0);
            wait_idle();
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the input backs up
    task automatic test_backpressure();
        tx_gaps = 1'b0;
        rx_hold = HOLD_CYCLES;
        for (int i = 0; i < 15; i++)
            send_sample(rand_sample(), rand_sample(), i == 0);
        wait_idle();
        tx_gaps = 1'b1;
    endtask

    // Run state must survive an idle stretch
    task automatic test_drain_pause();
        for (int i = 0; i < 5; i++)
            send_sample(rand_sample(), rand_sample(), i == 0);
        wait_idle();
        for (int i = 0; i < 5; i++)
            send_sample(rand_sample(), rand_sample(), 1'b0);
        wait_idle();
    endtask

    task automatic test_overflow();
        reg_write(REG_DT_SCALE, $urandom_range(0, 65535));
        for (int i = 0; i < RUN_MAX; i++)
            send_sample(rand_sample(), rand_sample(), i == 0);
        send_sample(16'h7FFF, 16'h7FFF, 1'b0);
        send_sample(16'h8000, 16'h8000, 1'b0);
        send_sample(rand_sample(), rand_sample(), 1'b0);
        // start mark clears the full condition
        send_sample(rand_sample(), rand_sample(), 1'b1);
        wait_idle();
    endtask

    task automatic test_random_runs();
        int   sent;
        int   len;
        logic start;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                wait_idle();
                reg_write(REG_DT_SCALE, $urandom_range(0, 65535));
            end
            tx_gaps   = $urandom_range(0, 3) != 0;
            rx_stalls = $urandom_range(0, 3) != 0;
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 12);
            start = $urandom_range(0, 7) != 0;
            for (int i = 0; i < len; i++) begin
                send_sample(rand_sample(), rand_sample(),
                            (i == 0) ? start : ($urandom_range(0, 31) == 0));
                sent++;
            end
        end
        wait_idle();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    initial begin : result_monitor
        conv_result_t       want;
        logic [Y_W-1:0]     got_y;
        logic [INDEX_W-1:0] got_index;
        logic               got_ovf;
        int                 stall;
        m_axis_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold > 0) begin
                @(negedge aclk);
                m_axis_tready <= 1'b0;
                repeat (rx_hold) @(negedge aclk);
                rx_hold = 0;
            end
            stall = rx_stalls ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                @(negedge aclk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            got_y     = m_axis_tdata[Y_W-1:0];
            got_index = m_axis_tdata[Y_W +: INDEX_W];
            got_ovf   = m_axis_tuser[0];
            if (conv_expect.size() == 0) begin
                $error("unexpected result item: y %0d, index %0d, overflow %0d",
                       $signed(got_y), got_index, got_ovf);
                fails++;
            end else begin
                want = conv_expect.pop_front();
                if (got_y !== want.y) begin
                    $error("y: expected %0d, got %0d", $signed(want.y), $signed(got_y));
                    fails++;
                end
                if (got_index !== want.index) begin
                    $error("index: expected %0d, got %0d", want.index, got_index);
                    fails++;
                end
                if (got_ovf !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, got_ovf);
                    fails++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        test_register_access();
        test_first_without_start();
        test_start_mark();
        test_scale_extremes();
        test_backpressure();
        test_drain_pause();
        test_overflow();
        test_random_runs();

        for (int i = 0; i < DRAIN_LIMIT && conv_expect.size() != 0; i++)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (conv_expect.size() != 0) begin
            $error("%0d result items never arrived", conv_expect.size());
            fails++;
        end
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
